// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the plucked string core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define PSS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check that a condition is followed by an outcome on the next edge
`define PSS_ASSERT_NEXT(label, pre, post, msg) \
   `PSS_ASSERT(label, (pre) |=> (post), msg)

`endif

// ===== hw/rtl/pss_pkg.sv =====
// Types and constants of the plucked string core
package pss_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEFF_W   = 16;
   localparam int INDEX_W   = 32;
   localparam int ACTION_W  = 2;
   localparam int CHAN_W    = 3;
   localparam int LPOS_W    = 12;
   localparam int LENREG_W  = 13;
   localparam int NCHREG_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // action codes of a request word
   localparam logic [ACTION_W-1:0] ACT_READ    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

   // control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_A      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_B      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CHANNELS = 2'd3;

   // control register reset values
   localparam logic [LENREG_W-1:0]       DELAY_LENGTH_RST = 13'd100;
   localparam logic signed [COEFF_W-1:0] COEFF_A_RST      = 16'sd8192;
   localparam logic signed [COEFF_W-1:0] COEFF_B_RST      = 16'sd8192;
   localparam logic [NCHREG_W-1:0]       NUM_CHANNELS_RST = 4'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADV_RD,
      ST_ADV_MUL,
      ST_ADV_WR,
      ST_RD,
      ST_RESULT
   } pss_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic load_wr;
      logic restart;
      logic advance;
      logic adv_rd;
      logic adv_mul;
      logic adv_wr;
      logic rd_issue;
      logic rsp_load;
   } pss_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic idx_neg;
      logic idx_new;
      logic adv_none;
      logic ch_last;
   } pss_sts_type;

endpackage

// ===== hw/rtl/pss_req_if.sv =====
// Request channel of the plucked string core
interface pss_req_if;
   import pss_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [ACTION_W-1:0]         action;
   logic [CHAN_W-1:0]           channel;
   logic signed [INDEX_W-1:0]   sample_index;
   logic [LPOS_W-1:0]           load_position;
   logic signed [SAMPLE_W-1:0]  load_sample;

   modport source (output valid, action, channel, sample_index, load_position, load_sample,
                   input ready);
   modport sink   (input valid, action, channel, sample_index, load_position, load_sample,
                   output ready);
endinterface

// ===== hw/rtl/pss_rsp_if.sv =====
// Response channel of the plucked string core
interface pss_rsp_if;
   import pss_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

// ===== hw/rtl/pss_ctrl.sv =====
// Sequencer of the plucked string core: handshakes and update loop
`include "assert_macros.svh"

module pss_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [pss_pkg::ACTION_W-1:0]      req_action,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  pss_pkg::pss_sts_type              sts,
   output pss_pkg::pss_cmd_type              cmd
);
   import pss_pkg::*;

   pss_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // hold state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = (rsp_valid_ff && !rsp_ready);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (req_action)
                  ACT_READ: begin
                     if (sts.idx_neg) begin
                        state_in = ST_RESULT;
                     end else if (sts.idx_new) begin
                        cmd.advance = 1'b1;
                        state_in    = sts.adv_none ? ST_RD : ST_ADV_RD;
                     end else begin
                        state_in = ST_RD;
                     end
                  end
                  ACT_LOAD:    cmd.load_wr = 1'b1;
                  ACT_RESTART: cmd.restart = 1'b1;
                  default:     ;
               endcase
            end
         end
         ST_ADV_RD: begin
            cmd.adv_rd = 1'b1;
            state_in   = ST_ADV_MUL;
         end
         ST_ADV_MUL: begin
            cmd.adv_mul = 1'b1;
            state_in    = ST_ADV_WR;
         end
         ST_ADV_WR: begin
            cmd.adv_wr = 1'b1;
            state_in   = sts.ch_last ? ST_RD : ST_ADV_RD;
         end
         ST_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `PSS_ASSERT_NEXT(a_neg_read_skips, req_fire && req_action == ACT_READ && sts.idx_neg, state_ff == ST_RESULT, "negative index read did not go straight to result")
   `PSS_ASSERT_NEXT(a_no_result_quiet, req_fire && req_action != ACT_READ, state_ff == ST_IDLE && !cmd.rsp_load, "load or restart word did not finish in one cycle")
   `PSS_ASSERT_NEXT(a_last_chan_reads, state_ff == ST_ADV_WR && sts.ch_last, state_ff == ST_RD, "update loop did not end after last channel")
   `PSS_ASSERT(a_rsp_from_result, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESULT, "response raised outside result state")

endmodule

// ===== hw/rtl/pss_datapath.sv =====
// Datapath of the plucked string core: registers, delay memory and mixer
module pss_datapath #(
   parameter int MAX_LENGTH   = 4096,
   parameter int MAX_CHANNELS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [pss_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pss_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  logic [pss_pkg::CHAN_W-1:0]            req_channel,
   input  logic signed [pss_pkg::INDEX_W-1:0]    req_sample_index,
   input  logic [pss_pkg::LPOS_W-1:0]            req_load_position,
   input  logic signed [pss_pkg::SAMPLE_W-1:0]   req_load_sample,
   output logic signed [pss_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input  pss_pkg::pss_cmd_type                  cmd,
   output pss_pkg::pss_sts_type                  sts
);
   import pss_pkg::*;

   localparam int POS_W     = $clog2(MAX_LENGTH);
   localparam int LEN_W     = $clog2(MAX_LENGTH + 1);
   localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W     = $clog2(MAX_CHANNELS + 1);
   localparam int MEM_DEPTH = MAX_CHANNELS * MAX_LENGTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int SUM_W     = 2 * SAMPLE_W + 2;

   // control registers
   logic [LENREG_W-1:0]        delay_length_ff;
   logic signed [COEFF_W-1:0]  coeff_a_ff;
   logic signed [COEFF_W-1:0]  coeff_b_ff;
   logic [NCHREG_W-1:0]        num_channels_ff;

   // string state
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic signed [INDEX_W-1:0]  held_ff;
   logic signed [SAMPLE_W-1:0] prev_ff [MAX_CHANNELS];
   logic [CH_W-1:0]            chan_idx_ff;

   // captured read word
   logic                       neg_ff;
   logic                       chan_ok_ff;
   logic [CH_W-1:0]            chan_ff;

   // mixer pipeline
   logic signed [2*SAMPLE_W-1:0] pa_ff;
   logic signed [2*SAMPLE_W-1:0] pb_ff;
   logic signed [SUM_W-1:0]      sum_w;
   logic signed [SUM_W-1:0]      quot_w;
   logic signed [SAMPLE_W-1:0]   mix_w;

   // delay memory
   logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       rd_en, wr_en;
   logic [ADDR_W-1:0]          rd_addr, wr_addr, adv_addr;
   logic signed [SAMPLE_W-1:0] wr_data;

   logic signed [SAMPLE_W-1:0] rsp_data_ff;

   logic [31:0]                len32;
   logic [LEN_W-1:0]           len_eff;
   logic [LEN_W-1:0]           pos_inc;
   logic [CNT_W-1:0]           n_eff;
   logic                       req_chan_ok;
   logic                       load_ok;

   function automatic logic [ADDR_W-1:0] mem_addr(input logic [31:0] ch, input logic [31:0] p);
      mem_addr = ADDR_W'(ch * 32'(MAX_LENGTH) + p);
   endfunction

   // decode control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_length_ff <= DELAY_LENGTH_RST;
         coeff_a_ff      <= COEFF_A_RST;
         coeff_b_ff      <= COEFF_B_RST;
         num_channels_ff <= NUM_CHANNELS_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DELAY_LENGTH: delay_length_ff <= csr_write_data[LENREG_W-1:0];
            CSR_COEFF_A:      coeff_a_ff      <= csr_write_data;
            CSR_COEFF_B:      coeff_b_ff      <= csr_write_data;
            CSR_NUM_CHANNELS: num_channels_ff <= csr_write_data[NCHREG_W-1:0];
            default:          ;
         endcase
      end
   end

   // clamp length and channel count
   always_comb begin
      len32 = 32'(delay_length_ff);
      if (len32 < 32'd2) begin
         len32 = 32'd2;
      end else if (len32 > 32'(MAX_LENGTH)) begin
         len32 = 32'(MAX_LENGTH);
      end
      len_eff = len32[LEN_W-1:0];
      if (32'(num_channels_ff) > 32'(MAX_CHANNELS)) begin
         n_eff = CNT_W'(MAX_CHANNELS);
      end else begin
         n_eff = CNT_W'(num_channels_ff);
      end
   end

   // advance position with wrap
   assign pos_inc = LEN_W'(pos_ff) + LEN_W'(1);
   assign pos_in  = (pos_inc >= len_eff) ? '0 : pos_inc[POS_W-1:0];

   assign req_chan_ok = (32'(req_channel) < 32'(MAX_CHANNELS));
   assign load_ok     = req_chan_ok && (32'(req_load_position) < 32'(MAX_LENGTH));

   // status for the sequencer
   assign sts.idx_neg  = req_sample_index[INDEX_W-1];
   assign sts.idx_new  = (req_sample_index != held_ff);
   assign sts.adv_none = (n_eff == '0);
   assign sts.ch_last  = ((32'(chan_idx_ff) + 32'd1) == 32'(n_eff));

   // hold position, held index, previous samples and loop channel
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         pos_ff      <= '0;
         held_ff     <= '0;
         chan_idx_ff <= '0;
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            prev_ff[c] <= '0;
         end
      end else if (cmd.advance) begin
         pos_ff      <= pos_in;
         held_ff     <= req_sample_index;
         chan_idx_ff <= '0;
      end else if (cmd.adv_wr) begin
         prev_ff[chan_idx_ff] <= rd_data_ff;
         chan_idx_ff          <= chan_idx_ff + CH_W'(1);
      end
   end

   // capture the fields a read needs later
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         neg_ff     <= req_sample_index[INDEX_W-1];
         chan_ok_ff <= req_chan_ok;
         chan_ff    <= req_chan_ok ? CH_W'(req_channel) : '0;
      end
   end

   // multiply previous, then current sample
   always_ff @(posedge clock) begin
      if (cmd.adv_rd) begin
         pa_ff <= coeff_a_ff * prev_ff[chan_idx_ff];
      end
      if (cmd.adv_mul) begin
         pb_ff <= coeff_b_ff * rd_data_ff;
      end
   end

   // sum, round half up, saturate
   always_comb begin
      sum_w  = SUM_W'(pa_ff) + SUM_W'(pb_ff) + SUM_W'(1 << 13);
      quot_w = sum_w >>> 14;
      if (quot_w > SUM_W'(32767)) begin
         mix_w = 16'sh7FFF;
      end else if (quot_w < -SUM_W'(32768)) begin
         mix_w = 16'sh8000;
      end else begin
         mix_w = quot_w[SAMPLE_W-1:0];
      end
   end

   // memory ports
   assign adv_addr = mem_addr(32'(chan_idx_ff), 32'(pos_ff));
   assign rd_en    = cmd.adv_rd || cmd.rd_issue;
   assign rd_addr  = cmd.rd_issue ? mem_addr(32'(chan_ff), 32'(pos_ff)) : adv_addr;
   assign wr_en    = (cmd.load_wr && load_ok) || cmd.adv_wr;
   assign wr_addr  = cmd.adv_wr ? adv_addr
                                : mem_addr(32'(req_channel), 32'(req_load_position));
   assign wr_data  = cmd.adv_wr ? mix_w : req_load_sample;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= (neg_ff || !chan_ok_ff) ? '0 : rd_data_ff;
      end
   end

   assign rsp_sample_out = rsp_data_ff;

endmodule

// ===== hw/rtl/plucked_string_synth_core.sv =====
// Top level of the multi-channel plucked string synthesizer
//
// Multi-channel plucked string: one delay line per channel of up to MAX_LENGTH
// samples, all stepping one shared position. Fill the lines with an excitation
// through load words, restart the string, then read. A load, restart or unused
// action gives no response. A read with a negative index returns 0 and skips
// the memory; a read at the held index reads the memory at the shared position.
// A read with a new index first updates every active channel in turn: read the
// delay memory, multiply the previous and the current sample, write back the
// blend. A finished response sits in an output register, and the next word is
// taken while it waits.
module plucked_string_synth_core #(
   parameter int MAX_LENGTH   = 4096,
   parameter int MAX_CHANNELS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   pss_req_if.sink                         req_ch,
   pss_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_en,
   input  logic [pss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pss_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import pss_pkg::*;

   pss_cmd_type cmd;
   pss_sts_type sts;

   pss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pss_datapath #(
      .MAX_LENGTH   (MAX_LENGTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_channel       (req_ch.channel),
      .req_sample_index  (req_ch.sample_index),
      .req_load_position (req_ch.load_position),
      .req_load_sample   (req_ch.load_sample),
      .rsp_sample_out    (rsp_ch.sample_out),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

// ===== tb/plucked_string_synth_core_tb.sv =====
// Self-checking testbench for the plucked string core: directed and random words vs. a predictor
module plucked_string_synth_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pss_pkg::*;

   localparam int LINE_DEPTH   = 4096;
   localparam int NUM_LINES    = 8;
   localparam int IDLE_PCT     = 21;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int MAX_REPORTS  = 100;

   // action code the core ignores
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]        action;
      logic [CHAN_W-1:0]          channel;
      logic signed [INDEX_W-1:0]  sample_index;
      logic [LPOS_W-1:0]          load_position;
      logic signed [SAMPLE_W-1:0] load_sample;
   } string_word_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   pss_req_if req_ch();
   pss_rsp_if rsp_ch();

   plucked_string_synth_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // string state as the predictor sees it
   logic signed [SAMPLE_W-1:0] line_mem [NUM_LINES][LINE_DEPTH];
   bit                         line_written [NUM_LINES][LINE_DEPTH];
   logic signed [SAMPLE_W-1:0] last_sample [NUM_LINES];
   int unsigned                line_pos;
   logic [INDEX_W-1:0]         held_idx;
   logic [LENREG_W-1:0]        len_cfg;
   logic signed [COEFF_W-1:0]  a_cfg;
   logic signed [COEFF_W-1:0]  b_cfg;
   logic [NCHREG_W-1:0]        nch_cfg;

   logic signed [SAMPLE_W-1:0] expected_samples [$];
   logic signed [SAMPLE_W-1:0] want_sample;
   int  error_count = 0;
   int  cycle_count = 0;
   bit  steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // stall the response side at random
   always @(posedge clock) begin
      rsp_ch.ready <= !reset && (steady || $urandom_range(0, 99) >= IDLE_PCT);
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS)
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // compare each accepted response word with the oldest expected sample
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected sample_out %0d", rsp_ch.sample_out));
         end else begin
            want_sample = expected_samples.pop_front();
            if (rsp_ch.sample_out !== want_sample)
               report_mismatch($sformatf("sample_out %0d, expected %0d",
                                         rsp_ch.sample_out, want_sample));
         end
      end
   end

   function automatic void model_reset();
      line_pos = 0;
      held_idx = '0;
      foreach (last_sample[c]) last_sample[c] = '0;
      len_cfg = DELAY_LENGTH_RST;
      a_cfg   = COEFF_A_RST;
      b_cfg   = COEFF_B_RST;
      nch_cfg = NUM_CHANNELS_RST;
   endfunction

   function automatic int unsigned active_length();
      if (len_cfg < 2) return 2;
      if (len_cfg > LINE_DEPTH) return LINE_DEPTH;
      return 32'(len_cfg);
   endfunction

   function automatic int unsigned active_channels();
      return (nch_cfg > NUM_LINES) ? NUM_LINES : 32'(nch_cfg);
   endfunction

   function automatic int unsigned next_position();
      int unsigned p;
      p = line_pos + 1;
      if (p >= active_length()) p = 0;
      return p;
   endfunction

   // a*prev + b*cur in Q3.29, round half up to Q1.15, saturate
   function automatic logic signed [SAMPLE_W-1:0] blend(input logic signed [SAMPLE_W-1:0] prev,
                                                         input logic signed [SAMPLE_W-1:0] cur);
      longint acc;
      acc = longint'(a_cfg) * longint'(prev) + longint'(b_cfg) * longint'(cur) + 64'sd8192;
      acc = acc >>> 14;
      if (acc > 32767) return 16'sh7FFF;
      if (acc < -32768) return 16'sh8000;
      return acc[SAMPLE_W-1:0];
   endfunction

   // advance the predicted string by one accepted word, queue its sample if any
   function automatic void pluck_step(input string_word_type w);
      logic signed [SAMPLE_W-1:0] cur;
      case (w.action)
         ACT_READ: begin
            if (w.sample_index[INDEX_W-1]) begin
               expected_samples.push_back('0);
            end else begin
               if (w.sample_index != held_idx) begin
                  held_idx = w.sample_index;
                  line_pos = next_position();
                  for (int c = 0; c < active_channels(); c++) begin
                     cur = line_mem[c][line_pos];
                     line_mem[c][line_pos] = blend(last_sample[c], cur);
                     line_written[c][line_pos] = 1'b1;
                     last_sample[c] = cur;
                  end
               end
               expected_samples.push_back(line_mem[w.channel][line_pos]);
            end
         end
         ACT_LOAD: begin
            line_mem[w.channel][w.load_position] = w.load_sample;
            line_written[w.channel][w.load_position] = 1'b1;
         end
         ACT_RESTART: begin
            line_pos = 0;
            held_idx = '0;
            foreach (last_sample[c]) last_sample[c] = '0;
         end
         default: ;
      endcase
   endfunction

   function automatic string_word_type make_word(input logic [ACTION_W-1:0] act,
                                                 input logic [CHAN_W-1:0] ch,
                                                 input logic [INDEX_W-1:0] idx,
                                                 input logic [LPOS_W-1:0] lp,
                                                 input logic [SAMPLE_W-1:0] smp);
      string_word_type w;
      w.action        = act;
      w.channel       = ch;
      w.sample_index  = idx;
      w.load_position = lp;
      w.load_sample   = smp;
      return w;
   endfunction

   // send one request word; valid stays high into the next call unless it idles
   task automatic push_word(input string_word_type w);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.action        <= w.action;
      req_ch.channel       <= w.channel;
      req_ch.sample_index  <= w.sample_index;
      req_ch.load_position <= w.load_position;
      req_ch.load_sample   <= w.load_sample;
      do @(posedge clock); while (!req_ch.ready);
      pluck_step(w);
   endtask

   task automatic load_entry(input logic [CHAN_W-1:0] ch, input logic [LPOS_W-1:0] lp,
                             input logic [SAMPLE_W-1:0] smp);
      push_word(make_word(ACT_LOAD, ch, $urandom, lp, smp));
   endtask

   task automatic restart_string();
      push_word(make_word(ACT_RESTART, CHAN_W'($urandom), $urandom, LPOS_W'($urandom),
                          SAMPLE_W'($urandom)));
   endtask

   // fill every entry the read will touch that was never written, then read
   task automatic read_sample(input logic [CHAN_W-1:0] ch, input logic [INDEX_W-1:0] idx);
      int unsigned np;
      np = line_pos;
      if (!idx[INDEX_W-1] && idx != held_idx) begin
         np = next_position();
         for (int c = 0; c < active_channels(); c++)
            if (!line_written[c][np])
               load_entry(CHAN_W'(c), LPOS_W'(np), SAMPLE_W'($urandom));
      end
      if (!idx[INDEX_W-1] && !line_written[ch][np])
         load_entry(ch, LPOS_W'(np), SAMPLE_W'($urandom));
      push_word(make_word(ACT_READ, ch, idx, LPOS_W'($urandom), SAMPLE_W'($urandom)));
   endtask

   // drop valid, drain every expected sample, let a trailing word finish
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         CSR_DELAY_LENGTH: len_cfg = data[LENREG_W-1:0];
         CSR_COEFF_A:      a_cfg   = data;
         CSR_COEFF_B:      b_cfg   = data;
         CSR_NUM_CHANNELS: nch_cfg = data[NCHREG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input int len, input int a, input int b, input int nch);
      settle();
      write_reg(CSR_DELAY_LENGTH, CSR_DATA_W'(len));
      write_reg(CSR_COEFF_A, CSR_DATA_W'(a));
      write_reg(CSR_COEFF_B, CSR_DATA_W'(b));
      write_reg(CSR_NUM_CHANNELS, CSR_DATA_W'(nch));
      csr_write_en <= 1'b0;
   endtask

   // one random word, weighted toward reads that step the string
   task automatic random_word();
      int unsigned pick;
      logic [CHAN_W-1:0] ch;
      logic [LPOS_W-1:0] lp;
      pick = $urandom_range(0, 99);
      ch   = CHAN_W'($urandom_range(0, NUM_LINES - 1));
      if (pick < 45) begin
         read_sample(ch, held_idx + 1);
      end else if (pick < 53) begin
         read_sample(ch, held_idx);
      end else if (pick < 60) begin
         read_sample(ch, $urandom);
      end else if (pick < 66) begin
         read_sample(ch, {1'b1, 31'($urandom)});
      end else if (pick < 86) begin
         if ($urandom_range(0, 1)) lp = LPOS_W'($urandom_range(0, active_length() - 1));
         else lp = LPOS_W'($urandom);
         push_word(make_word(ACT_LOAD, ch, $urandom, lp, SAMPLE_W'($urandom)));
      end else if (pick < 91) begin
         restart_string();
      end else if (pick < 95) begin
         push_word(make_word(ACT_UNUSED, ch, $urandom, LPOS_W'($urandom),
                             SAMPLE_W'($urandom)));
      end else begin
         read_sample(ch, {1'b0, 31'($urandom)});
      end
   endtask

   // reset settings: reads at held and new indexes, silence, ignored words
   task automatic test_default_strings();
      restart_string();
      load_entry(3'd0, 12'd0, 16'sh7FFF);
      load_entry(3'd0, 12'd1, 16'sh8000);
      load_entry(3'd7, 12'hFFF, 16'sh8000);
      load_entry(3'd3, 12'hFFF, 16'sh7FFF);
      read_sample(3'd0, 32'd0);
      read_sample(3'd0, 32'd1);
      read_sample(3'd0, 32'd1);
      read_sample(3'd0, 32'hFFFF_FFFF);
      read_sample(3'd5, 32'h8000_0000);
      read_sample(3'd7, 32'h7FFF_FFFF);
      push_word(make_word(ACT_UNUSED, 3'd6, 32'hFFFF_FFFF, 12'hFFF, 16'hFFFF));
      restart_string();
      read_sample(3'd0, 32'd0);
      read_sample(3'd0, 32'd5);
   endtask

   // full-scale samples and coefficients drive the blend into both rails
   task automatic test_saturation();
      configure(3, 32767, 32767, 2);
      restart_string();
      for (int p = 0; p < 3; p++) begin
         load_entry(3'd0, LPOS_W'(p), 16'sh7FFF);
         load_entry(3'd1, LPOS_W'(p), 16'sh8000);
      end
      for (int i = 1; i <= 4; i++) read_sample(CHAN_W'(i % 2), i);
      configure(3, 16'h8000, 32767, 2);
      restart_string();
      for (int i = 1; i <= 3; i++) read_sample(CHAN_W'(i % 2), i);
   endtask

   // clamped length and channel count, shrink below position
   task automatic test_length_limits();
      configure(0, 8192, 8192, 0);
      restart_string();
      for (int i = 1; i <= 3; i++) read_sample(3'd0, i);
      configure(1, 8192, 8192, 15);
      for (int i = 4; i <= 6; i++) read_sample(3'd7, i);
      steady = 1'b1;
      configure(8191, 16384, 0, 0);
      restart_string();
      for (int i = 1; i <= 12; i++) read_sample(CHAN_W'($urandom_range(0, 7)), i);
      configure(3, 8192, 8192, 15);
      steady = 1'b0;
      read_sample(CHAN_W'($urandom_range(0, 7)), 5000);
      read_sample(CHAN_W'($urandom_range(0, 7)), 5001);
   endtask

   // several random settings, extremes first, each with a run of random words
   task automatic test_random_phases();
      int len;
      int a;
      int b;
      int nch;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin len = 2; a = 16'h8000; b = 16'h8000; nch = 8; end
            1: begin len = 4096; a = 32767; b = 16'h8000; nch = 8; end
            default: begin
               case ($urandom_range(0, 9))
                  0: len = $urandom_range(0, 1);
                  1: len = $urandom_range(LINE_DEPTH, 8191);
                  default: len = $urandom_range(2, 48);
               endcase
               if ($urandom_range(0, 1)) begin
                  a = $urandom_range(0, 65535);
                  b = $urandom_range(0, 65535);
               end else begin
                  a = $urandom_range(4096, 12288);
                  b = $urandom_range(4096, 12288);
               end
               nch = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            end
         endcase
         configure(len, a, b, nch);
         for (int i = 0; i < 70; i++) random_word();
      end
   endtask

   // back-to-back words with both sides always ready
   task automatic test_streaming();
      steady = 1'b1;
      configure($urandom_range(2, 32), $urandom_range(4096, 12288),
                $urandom_range(4096, 12288), $urandom_range(1, 8));
      for (int i = 0; i < 200; i++) random_word();
      settle();
      steady = 1'b0;
   endtask

   initial begin
      reset                <= 1'b1;
      csr_write_en         <= 1'b0;
      csr_index            <= '0;
      csr_write_data       <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.action        <= ACT_READ;
      req_ch.channel       <= '0;
      req_ch.sample_index  <= '0;
      req_ch.load_position <= '0;
      req_ch.load_sample   <= '0;
      model_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_default_strings();
      test_saturation();
      test_length_limits();
      test_random_phases();
      test_streaming();
      settle();

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
